FILE: rtl/frustum_aabb_cull_top_macros.svh
// Assertion macros shared by the frustum cull RTL.
// Each use expects clk and rst_n in the enclosing scope.
`ifndef FRUSTUM_AABB_CULL_TOP_MACROS_SVH
`define FRUSTUM_AABB_CULL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FAC_ASSERT_IMP(lbl, ante, cons, msg)
`define FAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/fac_pkg.sv
package fac_pkg;

    localparam int NUM_AXES        = 3;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_ROWS        = 4;
    localparam int REG_WIDTH       = 64;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int FRAC_ALIGN      = 8;
    localparam int NUM_IN_FIELDS   = 9;
    localparam int OUT_TDATA_WIDTH = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MATRIX_COL0 = 2'd0,
        REG_MATRIX_COL1 = 2'd1,
        REG_MATRIX_COL2 = 2'd2,
        REG_MATRIX_COL3 = 2'd3
    } reg_index_t;

    localparam logic [REG_WIDTH-1:0] RESET_COL0 = 64'd4096;
    localparam logic [REG_WIDTH-1:0] RESET_COL1 = 64'd268435456;
    localparam logic [REG_WIDTH-1:0] RESET_COL2 = 64'd17592186044416;
    localparam logic [REG_WIDTH-1:0] RESET_COL3 = 64'd1152921504606846976;

endpackage

FILE: rtl/fac_planes.sv
`include "frustum_aabb_cull_top_macros.svh"

module fac_planes #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index,
    input  logic [fac_pkg::REG_WIDTH-1:0]                cfg_data,
    output logic signed [COEF_WIDTH:0]                   normal [fac_pkg::NUM_PLANES]
                                                                [fac_pkg::NUM_AXES],
    output logic signed [COEF_WIDTH+fac_pkg::FRAC_ALIGN:0] offset [fac_pkg::NUM_PLANES]
);

    localparam int LANES_W = fac_pkg::NUM_ROWS * COEF_WIDTH;
    localparam int OFS_W   = COEF_WIDTH + fac_pkg::FRAC_ALIGN + 1;

    logic [fac_pkg::REG_WIDTH-1:0]  col_reg [fac_pkg::NUM_ROWS];
    logic [LANES_W-1:0]             lanes [fac_pkg::NUM_ROWS];
    logic signed [COEF_WIDTH-1:0]   entry [fac_pkg::NUM_ROWS][fac_pkg::NUM_ROWS];
    logic signed [COEF_WIDTH:0]     normal_next [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES];
    logic signed [COEF_WIDTH:0]     normal_reg [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES];
    logic signed [OFS_W-1:0]        offset_next [fac_pkg::NUM_PLANES];
    logic signed [OFS_W-1:0]        offset_reg [fac_pkg::NUM_PLANES];
    logic signed [COEF_WIDTH+1:0]   pair_sum;
    logic signed [COEF_WIDTH+1:0]   twice_row3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0] <= fac_pkg::RESET_COL0;
            col_reg[1] <= fac_pkg::RESET_COL1;
            col_reg[2] <= fac_pkg::RESET_COL2;
            col_reg[3] <= fac_pkg::RESET_COL3;
        end
        else if (cfg_we)
        begin
            unique case (fac_pkg::reg_index_t'(cfg_index))
                fac_pkg::REG_MATRIX_COL0: col_reg[0] <= cfg_data;
                fac_pkg::REG_MATRIX_COL1: col_reg[1] <= cfg_data;
                fac_pkg::REG_MATRIX_COL2: col_reg[2] <= cfg_data;
                fac_pkg::REG_MATRIX_COL3: col_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // rows past the top of a column read as zero
    always_comb
    begin
        for (int c = 0; c < fac_pkg::NUM_ROWS; c++)
        begin
            lanes[c] = LANES_W'(col_reg[c]);
            for (int r = 0; r < fac_pkg::NUM_ROWS; r++)
            begin
                entry[r][c] = lanes[c][r*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    // plane 2k is row 3 plus row k, plane 2k+1 is row 3 minus row k
    always_comb
    begin
        for (int k = 0; k < fac_pkg::NUM_AXES; k++)
        begin
            for (int a = 0; a < fac_pkg::NUM_AXES; a++)
            begin
                normal_next[2*k][a]   = (COEF_WIDTH+1)'(entry[3][a])
                                      + (COEF_WIDTH+1)'(entry[k][a]);
                normal_next[2*k+1][a] = (COEF_WIDTH+1)'(entry[3][a])
                                      - (COEF_WIDTH+1)'(entry[k][a]);
            end
            offset_next[2*k]   = OFS_W'((COEF_WIDTH+1)'(entry[3][3])
                                 + (COEF_WIDTH+1)'(entry[k][3])) <<< fac_pkg::FRAC_ALIGN;
            offset_next[2*k+1] = OFS_W'((COEF_WIDTH+1)'(entry[3][3])
                                 - (COEF_WIDTH+1)'(entry[k][3])) <<< fac_pkg::FRAC_ALIGN;
        end
    end

    always_ff @(posedge clk)
    begin
        normal_reg <= normal_next;
        offset_reg <= offset_next;
    end

    assign normal = normal_reg;
    assign offset = offset_reg;

    assign pair_sum   = (COEF_WIDTH+2)'(normal_reg[0][0]) + (COEF_WIDTH+2)'(normal_reg[1][0]);
    assign twice_row3 = {entry[3][0][COEF_WIDTH-1], entry[3][0], 1'b0};

    `FAC_ASSERT_IMP(a_plane_pair_sum, 1'b1, pair_sum == $past(twice_row3), "x plane pair mismatch")

endmodule

FILE: rtl/fac_corner.sv
module fac_corner #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] box_min [fac_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] box_max [fac_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] pos [fac_pkg::NUM_AXES],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH:0]   corner_min [fac_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH:0]   corner_max [fac_pkg::NUM_AXES]
);

    logic                        valid_reg;
    logic signed [COORD_WIDTH:0] corner_min_reg [fac_pkg::NUM_AXES];
    logic signed [COORD_WIDTH:0] corner_max_reg [fac_pkg::NUM_AXES];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // offset both corners by the world position
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int a = 0; a < fac_pkg::NUM_AXES; a++)
            begin
                corner_min_reg[a] <= (COORD_WIDTH+1)'(box_min[a]) + (COORD_WIDTH+1)'(pos[a]);
                corner_max_reg[a] <= (COORD_WIDTH+1)'(box_max[a]) + (COORD_WIDTH+1)'(pos[a]);
            end
        end
    end

    assign out_valid  = valid_reg;
    assign corner_min = corner_min_reg;
    assign corner_max = corner_max_reg;

endmodule

FILE: rtl/fac_product.sv
module fac_product #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [COORD_WIDTH:0]               corner_min [fac_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH:0]               corner_max [fac_pkg::NUM_AXES],
    input  logic signed [COEF_WIDTH:0]                normal [fac_pkg::NUM_PLANES]
                                                             [fac_pkg::NUM_AXES],
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [COORD_WIDTH+COEF_WIDTH+1:0]  prod [fac_pkg::NUM_PLANES]
                                                           [fac_pkg::NUM_AXES]
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH + 2;

    logic                 valid_reg;
    logic signed [PW-1:0] prod_reg [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // take the far corner along each normal component: max unless negative
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int p = 0; p < fac_pkg::NUM_PLANES; p++)
            begin
                for (int a = 0; a < fac_pkg::NUM_AXES; a++)
                begin
                    prod_reg[p][a] <= normal[p][a]
                                    * (normal[p][a][COEF_WIDTH] ? corner_min[a] : corner_max[a]);
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

FILE: rtl/fac_reduce.sv
`include "frustum_aabb_cull_top_macros.svh"

module fac_reduce #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [COORD_WIDTH+COEF_WIDTH+1:0]     prod [fac_pkg::NUM_PLANES]
                                                              [fac_pkg::NUM_AXES],
    input  logic signed [COEF_WIDTH+fac_pkg::FRAC_ALIGN:0] offset [fac_pkg::NUM_PLANES],
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic                                         visible
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH + 2;
    localparam int AW = PW + 1;
    localparam int SW = PW + 2;

    logic                           part_valid_reg;
    logic signed [AW-1:0]           part_a_reg [fac_pkg::NUM_PLANES];
    logic signed [AW-1:0]           part_b_reg [fac_pkg::NUM_PLANES];
    logic                           out_valid_reg;
    logic                           visible_reg;
    logic                           slot_ready;
    logic signed [SW-1:0]           plane_dist [fac_pkg::NUM_PLANES];
    logic [fac_pkg::NUM_PLANES-1:0] behind;

    assign slot_ready = !out_valid_reg || out_ready;
    assign in_ready   = !part_valid_reg || slot_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                part_valid_reg <= in_valid;
            end
            if (slot_ready)
            begin
                out_valid_reg <= part_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int p = 0; p < fac_pkg::NUM_PLANES; p++)
            begin
                part_a_reg[p] <= AW'(prod[p][0]) + AW'(prod[p][1]);
                part_b_reg[p] <= AW'(prod[p][2]) + AW'(offset[p]);
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < fac_pkg::NUM_PLANES; p++)
        begin
            plane_dist[p] = SW'(part_a_reg[p]) + SW'(part_b_reg[p]);
            behind[p]     = plane_dist[p][SW-1];
        end
    end

    // drop the box if any plane has its far corner behind it
    always_ff @(posedge clk)
    begin
        if (slot_ready && part_valid_reg)
        begin
            visible_reg <= ~|behind;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

    `FAC_ASSERT_NXT(a_drain, part_valid_reg && !out_valid_reg, out_valid_reg, "part result lost")

endmodule

FILE: rtl/frustum_aabb_cull_top.sv
// Frustum visibility test for axis-aligned boxes. Each request carries a box
// (min and max corners relative to its position) and a world position, all
// signed Q16.8; the result is a single visible flag, 0 when some frustum plane
// has the box's far corner strictly behind it. The planes are formed from the
// view-projection matrix in matrix_col0..3 (Q4.12 entries, reset to identity)
// and refreshed through the column and plane registers after each write; write
// them only while no box is in flight. Throughput is one box per clock while
// m_tready is high, through four register stages: corner offset, eighteen
// parallel normal-by-corner multipliers, pairwise add, final add with sign
// test. Each stage has its own valid bit, so bubbles are squeezed out and
// s_tready only drops when every stage holds a request.
`include "frustum_aabb_cull_top_macros.svh"

module frustum_aabb_cull_top #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [fac_pkg::REG_WIDTH-1:0]        cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // pos_x, pos_y, pos_z, zero fill
    input  logic [((fac_pkg::NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // visible, zero fill
    output logic [fac_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata
);

    localparam int NA = fac_pkg::NUM_AXES;
    localparam int NP = fac_pkg::NUM_PLANES;
    localparam int PW = COORD_WIDTH + COEF_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0]             box_min [NA];
    logic signed [COORD_WIDTH-1:0]             box_max [NA];
    logic signed [COORD_WIDTH-1:0]             pos [NA];
    logic signed [COEF_WIDTH:0]                normal [NP][NA];
    logic signed [COEF_WIDTH+fac_pkg::FRAC_ALIGN:0] offset [NP];
    logic                                      corner_valid;
    logic                                      corner_ready;
    logic signed [COORD_WIDTH:0]               corner_min [NA];
    logic signed [COORD_WIDTH:0]               corner_max [NA];
    logic                                      prod_valid;
    logic                                      prod_ready;
    logic signed [PW-1:0]                      prod [NP][NA];
    logic                                      visible;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            box_min[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            box_max[a] = s_tdata[(NA+a)*COORD_WIDTH +: COORD_WIDTH];
            pos[a]     = s_tdata[(2*NA+a)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    fac_planes #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_planes (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .normal    (normal),
        .offset    (offset)
    );

    fac_corner #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_corner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .box_min    (box_min),
        .box_max    (box_max),
        .pos        (pos),
        .out_valid  (corner_valid),
        .out_ready  (corner_ready),
        .corner_min (corner_min),
        .corner_max (corner_max)
    );

    fac_product #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (corner_valid),
        .in_ready   (corner_ready),
        .corner_min (corner_min),
        .corner_max (corner_max),
        .normal     (normal),
        .out_valid  (prod_valid),
        .out_ready  (prod_ready),
        .prod       (prod)
    );

    fac_reduce #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod      (prod),
        .offset    (offset),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .visible   (visible)
    );

    assign m_tdata = {{(fac_pkg::OUT_TDATA_WIDTH-1){1'b0}}, visible};

    `FAC_ASSERT_IMP(a_stall_needs_full_out, !s_tready, m_tvalid, "input stalled with output empty")

endmodule
